### sv/swm_pkg.sv
// Shared constants for the sliding window mean block.
package swm_pkg;

  localparam int RING_DEPTH = 32;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SMP_W      = 16;
  localparam int LEN_W      = 6;
  localparam int SUM_W      = SMP_W + $clog2(RING_DEPTH);
  localparam int STEP_W     = $clog2(SUM_W);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

endpackage

### sv/sliding_window_mean.sv
// Moving average over a ring of signed samples, with an iterative divider.
// Mean from a restoring divider, one quotient bit a cycle. A new sample is
// taken only in the idle state, once the last result is in the output
// register, which frees the next sample while a result waits. Async
// active-low reset: window length 16, position, full flag and sum cleared;
// ring contents are not reset.
module sliding_window_mean import swm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [LEN_W-1:0]        cfg_window_length_i,
  input  logic                    sample_valid_i,
  output logic                    sample_ready_o,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic                    mean_valid_o,
  input  logic                    mean_ready_i,
  output logic signed [SMP_W-1:0] mean_o,
  output logic                    window_full_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [PTR_W-1:0]        pos_q, pos_d;
  logic                    filled_q, filled_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W-1:0]        dvd_q, dvd_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    neg_q, neg_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [SMP_W-1:0] out_mean_q, out_mean_d;
  logic                    out_full_q, out_full_d;

  logic signed [SMP_W-1:0] ring [RING_DEPTH];
  logic signed [SMP_W-1:0] old_q;
  logic signed [SMP_W-1:0] smp_q;

  logic [CNT_W-1:0]        eff_len;
  logic [PTR_W-1:0]        wr_pos;
  logic [CNT_W-1:0]        pos_inc;
  logic [CNT_W:0]          trial;
  logic [CNT_W:0]          diff;
  logic [SUM_W-1:0]        quo_mag;
  logic                    accept;
  logic                    cfg_wr;

  assign cfg_ready_o    = 1'b1;
  assign cfg_wr         = cfg_valid_i & cfg_ready_o;
  assign sample_ready_o = (state_q == S_IDLE);
  assign accept         = sample_valid_i & sample_ready_o;

  always_comb begin
    if (len_q == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(len_q) > RING_DEPTH) begin
      eff_len = CNT_W'(RING_DEPTH);
    end else begin
      eff_len = CNT_W'(len_q);
    end
  end

  assign wr_pos  = (CNT_W'(pos_q) >= eff_len) ? '0 : pos_q;
  assign pos_inc = CNT_W'(wr_pos) + CNT_W'(1);

  // one restoring step: shift in the next dividend bit, try subtracting
  assign trial   = {rem_q, dvd_q[SUM_W-1]};
  assign diff    = trial - {1'b0, eff_len};
  assign quo_mag = neg_q ? (~dvd_q + SUM_W'(1)) : dvd_q;

  // ring: read-first single port, old entry comes back for the subtraction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      old_q        <= ring[wr_pos];
      ring[wr_pos] <= sample_i;
      smp_q        <= sample_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pos_d       = pos_q;
    filled_d    = filled_q;
    sum_d       = sum_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    step_d      = step_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    out_mean_d  = out_mean_q;
    out_full_d  = out_full_q;

    if (out_valid_q && mean_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (pos_inc >= eff_len) begin
            pos_d    = '0;
          end else begin
            pos_d    = PTR_W'(pos_inc);
          end
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        sum_d = sum_q + {{(SUM_W-SMP_W){smp_q[SMP_W-1]}}, smp_q}
              - (filled_q ? {{(SUM_W-SMP_W){old_q[SMP_W-1]}}, old_q} : '0);
        // wrap of the write position marks the window as full
        if (pos_q == '0) begin
          filled_d = 1'b1;
        end
        state_d = S_PREP;
      end
      S_PREP: begin
        neg_d  = sum_q[SUM_W-1];
        dvd_d  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
        rem_d  = '0;
        step_d = STEP_W'(SUM_W - 1);
        if (filled_q) begin
          state_d = S_DIV;
        end else begin
          neg_d   = 1'b0;
          dvd_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (!diff[CNT_W]) begin
          rem_d = diff[CNT_W-1:0];
        end else begin
          rem_d = trial[CNT_W-1:0];
        end
        dvd_d = {dvd_q[SUM_W-2:0], ~diff[CNT_W]};
        if (step_q == '0) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || mean_ready_i) begin
          out_valid_d = 1'b1;
          out_mean_d  = quo_mag[SMP_W-1:0];
          out_full_d  = filled_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // configuration only arrives while idle is a rule for the user; the block itself does not enforce it
    if (cfg_wr) begin
      len_d    = cfg_window_length_i;
      pos_d    = '0;
      filled_d = 1'b0;
      sum_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= LEN_RESET;
      pos_q       <= '0;
      filled_q    <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      filled_q    <= filled_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    step_q     <= step_d;
    neg_q      <= neg_d;
    out_mean_q <= out_mean_d;
    out_full_q <= out_full_d;
  end

  assign mean_valid_o  = out_valid_q;
  assign mean_o        = out_mean_q;
  assign window_full_o = out_full_q;

endmodule

### sv/swm_checker.sv
// Port-level checks for the sliding window mean block, bound to its top level.
module swm_checker import swm_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    sample_valid_i,
  input logic                    sample_ready_o,
  input logic                    mean_valid_o,
  input logic                    mean_ready_i,
  input logic signed [SMP_W-1:0] mean_o,
  input logic                    window_full_o
);

  // mean is forced to zero until the window has filled
  a_zero_until_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_valid_o && !window_full_o |-> mean_o == '0)
    else $error("nonzero mean before window full");

  // the block is not ready for another sample right after a sample transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && sample_ready_o |=> !sample_ready_o)
    else $error("sample accepted while divider busy");

  // a stalled result holds
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_valid_o && !mean_ready_i |=> mean_valid_o && $stable(mean_o)
      && $stable(window_full_o))
    else $error("stalled result changed");

  // no result is shown while held in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !mean_valid_o)
    else $error("result valid during reset");

endmodule

bind sliding_window_mean swm_checker u_swm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .sample_valid_i (sample_valid_i),
  .sample_ready_o (sample_ready_o),
  .mean_valid_o   (mean_valid_o),
  .mean_ready_i   (mean_ready_i),
  .mean_o         (mean_o),
  .window_full_o  (window_full_o)
);
